/* rtl/vertex_weld_indexer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Vertex weld indexer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_WELD_INDEXER_UNIT_DEFINES_SVH
`define VERTEX_WELD_INDEXER_UNIT_DEFINES_SVH

// same-cycle implication
`define VWI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vwi_pkg.sv */
// ----------------------------------------------------------------------------
// vwi_pkg
// Types and constants of the vertex weld indexer.
// ----------------------------------------------------------------------------
package vwi_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned TEX_W   = 24;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned THR_W   = 30;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned VIDX_W  = 10;
  localparam int unsigned PROD_W  = 2 * NORM_W;
  localparam int unsigned DOT_W   = PROD_W + 2;

  localparam logic [TOL_W-1:0] POS_TOL_RST = 16'd41;
  localparam logic [TOL_W-1:0] TEX_TOL_RST = 16'd66;
  localparam logic [THR_W-1:0] COS_THR_RST = 30'd268167021;

  typedef enum logic [CIDX_W-1:0] {
    CFG_POS_TOL = 2'd0,
    CFG_TEX_TOL = 2'd1,
    CFG_COS_THR = 2'd2
  } vwi_cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [TEX_W-1:0]  tex_s;
    logic signed [TEX_W-1:0]  tex_t;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
  } vwi_vertex_t;

  typedef struct packed {
    logic [TOL_W-1:0] pos_tol;
    logic [TOL_W-1:0] tex_tol;
    logic [THR_W-1:0] cos_thr;
  } vwi_cfg_t;

endpackage

/* rtl/vwi_ifs.sv */
// ----------------------------------------------------------------------------
// vwi_ifs
// Valid/ready channel interfaces: vertex input, index result, register write.
// ----------------------------------------------------------------------------
interface vwi_in_if;
  import vwi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     start_mesh;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [TEX_W-1:0]  tex_s;
  logic signed [TEX_W-1:0]  tex_t;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;

  modport source (
    output valid, start_mesh, pos_x, pos_y, pos_z, tex_s, tex_t, norm_x, norm_y, norm_z,
    input  ready
  );
  modport sink (
    input  valid, start_mesh, pos_x, pos_y, pos_z, tex_s, tex_t, norm_x, norm_y, norm_z,
    output ready
  );
endinterface

interface vwi_out_if;
  import vwi_pkg::*;

  logic              valid;
  logic              ready;
  logic [VIDX_W-1:0] vertex_index;
  logic              is_new;
  logic              table_full;

  modport source (output valid, vertex_index, is_new, table_full, input ready);
  modport sink   (input valid, vertex_index, is_new, table_full, output ready);
endinterface

interface vwi_cfg_if;
  import vwi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [THR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/vwi_match.sv */
// ----------------------------------------------------------------------------
// vwi_match
// Two-stage compare of one stored entry against the current vertex:
// tolerance windows and normal products registered, dot product checked next.
// ----------------------------------------------------------------------------
module vwi_match (
  input  logic                clk,
  input  vwi_pkg::vwi_vertex_t entry,
  input  vwi_pkg::vwi_vertex_t item,
  input  vwi_pkg::vwi_cfg_t    cfg,
  output logic                match
);
  import vwi_pkg::*;

  logic                     win_ok;
  logic                     zero_both;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

  logic                     win_ok_r;
  logic                     zero_both_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  thr;

  function automatic logic in_window(input logic signed [POS_W:0] a,
                                     input logic signed [POS_W:0] b,
                                     input logic [TOL_W-1:0]      tol);
    logic signed [POS_W:0] d_ab;
    logic signed [POS_W:0] d_ba;
    logic signed [POS_W:0] t;
    d_ab = a - b;
    d_ba = b - a;
    t    = $signed({{(POS_W + 1 - TOL_W){1'b0}}, tol});
    return (d_ab <= t) && (d_ba <= t);
  endfunction

  always_comb begin
    win_ok =
      in_window((POS_W+1)'(entry.pos_x), (POS_W+1)'(item.pos_x), cfg.pos_tol) &&
      in_window((POS_W+1)'(entry.pos_y), (POS_W+1)'(item.pos_y), cfg.pos_tol) &&
      in_window((POS_W+1)'(entry.pos_z), (POS_W+1)'(item.pos_z), cfg.pos_tol) &&
      in_window((POS_W+1)'(entry.tex_s), (POS_W+1)'(item.tex_s), cfg.tex_tol) &&
      in_window((POS_W+1)'(entry.tex_t), (POS_W+1)'(item.tex_t), cfg.tex_tol);
    zero_both = (entry.norm_x == '0) && (entry.norm_y == '0) && (entry.norm_z == '0) &&
                (item.norm_x == '0) && (item.norm_y == '0) && (item.norm_z == '0);
    prod_x = entry.norm_x * item.norm_x;
    prod_y = entry.norm_y * item.norm_y;
    prod_z = entry.norm_z * item.norm_z;
  end

  always_ff @(posedge clk) begin
    win_ok_r    <= win_ok;
    zero_both_r <= zero_both;
    prod_x_r    <= prod_x;
    prod_y_r    <= prod_y;
    prod_z_r    <= prod_z;
  end

  always_comb begin
    dot   = DOT_W'(prod_x_r) + DOT_W'(prod_y_r) + DOT_W'(prod_z_r);
    thr   = $signed({{(DOT_W - THR_W){1'b0}}, cfg.cos_thr});
    match = win_ok_r && (zero_both_r || (dot >= thr));
  end

endmodule

/* rtl/vertex_weld_indexer_unit.sv */
// ----------------------------------------------------------------------------
// vertex_weld_indexer_unit
// Welds vertices within position, texture and normal tolerance against a
// table of unique vertices; answers the first match, the appended index or table_full.
// ----------------------------------------------------------------------------
//   channel  dir  transaction
//   in_if    in   one vertex, start_mesh clears the table first
//   out_if   out  vertex_index, is_new, table_full
//   cfg_if   in   register write: index, data (always ready)
//
// The table memory is read one entry a cycle until the first match and each
// read passes two compare stages; if no stored entry matches, the vertex is
// appended (table_full when at depth). The next vertex can be accepted in the
// cycle after the result is loaded.
// Reset clears control and loads register defaults; the table needs no clear.
// A waiting result does not block acceptance; the next result holds until it goes.
// ----------------------------------------------------------------------------
module vertex_weld_indexer_unit #(
  parameter int unsigned MAX_UNIQUE_VERTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  vwi_in_if.sink    in_if,
  vwi_out_if.source out_if,
  vwi_cfg_if.sink   cfg_if
);
  import vwi_pkg::*;

  `include "vertex_weld_indexer_unit_defines.svh"

  localparam int unsigned AW    = $clog2(MAX_UNIQUE_VERTS);
  localparam int unsigned CW    = $clog2(MAX_UNIQUE_VERTS + 1);
  localparam int unsigned XW    = (AW > VIDX_W) ? AW : VIDX_W;
  localparam logic [CW-1:0] MAX = CW'(MAX_UNIQUE_VERTS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

  state_t            state_r;
  vwi_cfg_t          cfg_r;
  vwi_vertex_t       item_r;
  vwi_vertex_t       mem [MAX_UNIQUE_VERTS];
  vwi_vertex_t       rd_data_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     issue_r;
  logic              v1_r, v2_r;
  logic [AW-1:0]     idx1_r, idx2_r;
  logic [AW-1:0]     res_idx_r;
  logic              res_new_r, res_full_r;
  logic              out_valid_r;
  logic [VIDX_W-1:0] out_idx_r;
  logic              out_new_r, out_full_r;

  logic              in_acc;
  logic              match;
  logic              hit;
  logic              issuing;
  logic              scan_done;
  logic              wen;
  logic [XW-1:0]     res_idx_ext;

  assign in_if.ready         = (state_r == S_IDLE);
  assign in_acc              = in_if.valid && in_if.ready;
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.vertex_index = out_idx_r;
  assign out_if.is_new       = out_new_r;
  assign out_if.table_full   = out_full_r;

  assign hit       = (state_r == S_SCAN) && v2_r && match;
  assign issuing   = (state_r == S_SCAN) && (issue_r < cnt_r) && !hit;
  assign scan_done = (state_r == S_SCAN) && (issue_r == cnt_r) && !v1_r && !v2_r;
  assign wen       = scan_done && (cnt_r < MAX);
  assign res_idx_ext = XW'(res_idx_r);

  vwi_match u_match (
    .clk   (clk),
    .entry (rd_data_r),
    .item  (item_r),
    .cfg   (cfg_r),
    .match (match)
  );

  // table memory
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[cnt_r[AW-1:0]] <= item_r;
    end
    if (issuing) begin
      rd_data_r <= mem[issue_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= '{pos_x: in_if.pos_x, pos_y: in_if.pos_y, pos_z: in_if.pos_z,
                  tex_s: in_if.tex_s, tex_t: in_if.tex_t,
                  norm_x: in_if.norm_x, norm_y: in_if.norm_y, norm_z: in_if.norm_z};
    end
    idx1_r <= issue_r[AW-1:0];
    idx2_r <= idx1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pos_tol: POS_TOL_RST, tex_tol: TEX_TOL_RST, cos_thr: COS_THR_RST};
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (vwi_cfg_idx_t'(cfg_if.index))
        CFG_POS_TOL: cfg_r.pos_tol <= cfg_if.data[TOL_W-1:0];
        CFG_TEX_TOL: cfg_r.tex_tol <= cfg_if.data[TOL_W-1:0];
        CFG_COS_THR: cfg_r.cos_thr <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      res_idx_r   <= '0;
      res_new_r   <= 1'b0;
      res_full_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_new_r   <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      v1_r <= issuing;
      v2_r <= v1_r && !hit;
      if (issuing) begin
        issue_r <= issue_r + 1'b1;
      end
      if (out_valid_r && out_if.ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            issue_r <= '0;
            if (in_if.start_mesh) begin
              cnt_r <= '0;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_idx_r  <= idx2_r;
            res_new_r  <= 1'b0;
            res_full_r <= 1'b0;
            state_r    <= S_RESP;
          end else if (scan_done) begin
            if (wen) begin
              res_idx_r  <= cnt_r[AW-1:0];
              res_new_r  <= 1'b1;
              res_full_r <= 1'b0;
              cnt_r      <= cnt_r + 1'b1;
            end else begin
              res_idx_r  <= '0;
              res_new_r  <= 1'b0;
              res_full_r <= 1'b1;
            end
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= res_idx_ext[VIDX_W-1:0];
            out_new_r   <= res_new_r;
            out_full_r  <= res_full_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VWI_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX, "unique count beyond table depth")
  `VWI_ASSERT_NOW(a_issue_bound, 1'b1, issue_r <= cnt_r, "read address past unique count")
  `VWI_ASSERT_NOW(a_full_only_at_max, (state_r == S_RESP) && res_full_r, cnt_r == MAX,
    "table full reported below depth")
  `VWI_ASSERT_NOW(a_write_idle_pipe, wen, !v1_r && !v2_r && !hit,
    "append while compares in flight")
  `VWI_ASSERT_NEXT(a_hit_flush, hit, !v1_r && !v2_r && (state_r == S_RESP),
    "compare pipeline not flushed after match")

endmodule
